### sv/sct_pkg.sv
`timescale 1ns / 1ps
package sct_pkg;

  // Scanner modes of the front part.
  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_NUM_INT,
    M_NUM_FRAC,
    M_STRING,
    M_GOT_EQ,
    M_GOT_BANG,
    M_GOT_GT,
    M_GOT_LT,
    M_ENDED,
    M_HALTED
  } scan_mode_t;

  // Token kinds.
  localparam logic [4:0] K_EOF      = 5'd0;
  localparam logic [4:0] K_NEWLINE  = 5'd1;
  localparam logic [4:0] K_IDENT    = 5'd2;
  localparam logic [4:0] K_NUMBER   = 5'd3;
  localparam logic [4:0] K_STRING   = 5'd4;
  localparam logic [4:0] K_TYPE     = 5'd5;
  localparam logic [4:0] K_SAY      = 5'd6;
  localparam logic [4:0] K_HEAR     = 5'd7;
  localparam logic [4:0] K_IF       = 5'd8;
  localparam logic [4:0] K_ELSE     = 5'd9;
  localparam logic [4:0] K_FN       = 5'd10;
  localparam logic [4:0] K_RETURN   = 5'd11;
  localparam logic [4:0] K_TRUE     = 5'd12;
  localparam logic [4:0] K_FALSE    = 5'd13;
  localparam logic [4:0] K_AND      = 5'd14;
  localparam logic [4:0] K_OR       = 5'd15;
  localparam logic [4:0] K_NOT      = 5'd16;
  localparam logic [4:0] K_LPAREN   = 5'd17;
  localparam logic [4:0] K_RPAREN   = 5'd18;
  localparam logic [4:0] K_LBRACE   = 5'd19;
  localparam logic [4:0] K_RBRACE   = 5'd20;
  localparam logic [4:0] K_LBRACKET = 5'd21;
  localparam logic [4:0] K_RBRACKET = 5'd22;
  localparam logic [4:0] K_COMMA    = 5'd23;
  localparam logic [4:0] K_SEMI     = 5'd24;
  localparam logic [4:0] K_ASSIGN   = 5'd25;
  localparam logic [4:0] K_OPERATOR = 5'd26;
  localparam logic [4:0] K_ERROR    = 5'd27;

  // Sub codes.
  localparam logic [3:0] SUB_NONE   = 4'd0;
  localparam logic [3:0] OP_EQ      = 4'd0;
  localparam logic [3:0] OP_NE      = 4'd1;
  localparam logic [3:0] OP_GE      = 4'd2;
  localparam logic [3:0] OP_GT      = 4'd3;
  localparam logic [3:0] OP_LE      = 4'd4;
  localparam logic [3:0] OP_LT      = 4'd5;
  localparam logic [3:0] OP_ADD     = 4'd6;
  localparam logic [3:0] OP_SUB     = 4'd7;
  localparam logic [3:0] OP_MUL     = 4'd8;
  localparam logic [3:0] OP_DIV     = 4'd9;
  localparam logic [3:0] TY_INT     = 4'd0;
  localparam logic [3:0] TY_FLOAT   = 4'd1;
  localparam logic [3:0] TY_TEXT    = 4'd2;
  localparam logic [3:0] TY_BOOLEAN = 4'd3;
  localparam logic [3:0] ERR_STRING = 4'd0;
  localparam logic [3:0] ERR_BANG   = 4'd1;
  localparam logic [3:0] ERR_AMP    = 4'd2;
  localparam logic [3:0] ERR_PIPE   = 4'd3;
  localparam logic [3:0] ERR_BYTE   = 4'd4;

  localparam int PREFIX_BYTES_DEF = 8;
  localparam int PREFIX_MAX_BITS  = 64;
  localparam int Q_DEPTH          = 4;
  localparam int Q_AW             = $clog2(Q_DEPTH);
  localparam int Q_CW             = $clog2(Q_DEPTH + 1);

  // One raw token as the front part produces it.
  typedef struct packed {
    logic [4:0]                 kind;
    logic [3:0]                 sub;
    logic [15:0]                start;
    logic [15:0]                len;
    logic                       last;
    logic [PREFIX_MAX_BITS-1:0] prefix;
  } tok_t;

  // Request from the front part into the queue.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       first;
    tok_t       second;
  } push_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [3:0] sub;
  } cls_t;

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [3:0] sub,
                                  input logic [15:0] start, input logic [15:0] len);
    tok_t t;
    t = '0;
    t.kind  = kind;
    t.sub   = sub;
    t.start = start;
    t.len   = len;
    return t;
  endfunction

  // Keyword and type name lookup from the length and the first bytes.
  function automatic cls_t word_lookup(input logic [PREFIX_MAX_BITS-1:0] p,
                                       input logic [15:0] len);
    logic [7:0] b0, b1, b2, b3, b4, b5, b6;
    cls_t r;
    b0 = p[7:0];
    b1 = p[15:8];
    b2 = p[23:16];
    b3 = p[31:24];
    b4 = p[39:32];
    b5 = p[47:40];
    b6 = p[55:48];
    r.kind = K_IDENT;
    r.sub  = SUB_NONE;
    if (len == 16'd2) begin
      if ({b0, b1} == "if") r.kind = K_IF;
      else if ({b0, b1} == "fn") r.kind = K_FN;
      else if ({b0, b1} == "or") r.kind = K_OR;
    end else if (len == 16'd3) begin
      if ({b0, b1, b2} == "say") r.kind = K_SAY;
      else if ({b0, b1, b2} == "and") r.kind = K_AND;
      else if ({b0, b1, b2} == "not") r.kind = K_NOT;
      else if ({b0, b1, b2} == "int") begin
        r.kind = K_TYPE;
        r.sub  = TY_INT;
      end
    end else if (len == 16'd4) begin
      if ({b0, b1, b2, b3} == "hear") r.kind = K_HEAR;
      else if ({b0, b1, b2, b3} == "else") r.kind = K_ELSE;
      else if ({b0, b1, b2, b3} == "true") r.kind = K_TRUE;
      else if ({b0, b1, b2, b3} == "text") begin
        r.kind = K_TYPE;
        r.sub  = TY_TEXT;
      end
    end else if (len == 16'd5) begin
      if ({b0, b1, b2, b3, b4} == "false") r.kind = K_FALSE;
      else if ({b0, b1, b2, b3, b4} == "float") begin
        r.kind = K_TYPE;
        r.sub  = TY_FLOAT;
      end
    end else if (len == 16'd6) begin
      if ({b0, b1, b2, b3, b4, b5} == "return") r.kind = K_RETURN;
    end else if (len == 16'd7) begin
      if ({b0, b1, b2, b3, b4, b5, b6} == "boolean") begin
        r.kind = K_TYPE;
        r.sub  = TY_BOOLEAN;
      end
    end
    return r;
  endfunction

endpackage

### sv/sct_front.sv
`timescale 1ns / 1ps
module sct_front #(
  parameter int PREFIX_BYTES = sct_pkg::PREFIX_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    char_code,
  output sct_pkg::push_t push
);
  import sct_pkg::*;

  localparam int PW = 8 * PREFIX_BYTES;

  scan_mode_t      mode_r, mode_nxt;
  logic [15:0]     pos_r, start_r, start_nxt, len_r, len_nxt;
  logic [PW-1:0]   prefix_r, prefix_nxt;
  tok_t            tok_a, tok_b;
  logic            va, vb, run_idle;
  logic            is_alpha, is_digit;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  assign is_alpha = (char_code >= "a" && char_code <= "z") ||
                    (char_code >= "A" && char_code <= "Z") || char_code == "_";
  assign is_digit = char_code >= "0" && char_code <= "9";

  // Scanner: pending token first, then the byte as a fresh start.
  always_comb begin
    tok_a      = '0;
    tok_b      = '0;
    va         = 1'b0;
    vb         = 1'b0;
    run_idle   = 1'b0;
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    prefix_nxt = prefix_r;
    unique case (mode_r)
      M_IDLE: run_idle = 1'b1;
      M_IDENT: begin
        if (is_alpha || is_digit) begin
          for (int i = 0; i < PREFIX_BYTES; i++) begin
            if (len_r == 16'(i)) prefix_nxt[8*i +: 8] = char_code;
          end
          len_nxt = sat_inc(len_r);
        end else begin
          va           = 1'b1;
          tok_a        = mk_tok(K_IDENT, SUB_NONE, start_r, len_r);
          tok_a.prefix = PREFIX_MAX_BITS'(prefix_r);
          mode_nxt     = M_IDLE;
          run_idle     = 1'b1;
        end
      end
      M_NUM_INT, M_NUM_FRAC: begin
        if (is_digit || (char_code == "." && mode_r == M_NUM_INT)) begin
          if (char_code == ".") mode_nxt = M_NUM_FRAC;
          len_nxt = sat_inc(len_r);
        end else begin
          va       = 1'b1;
          tok_a    = mk_tok(K_NUMBER, SUB_NONE, start_r, len_r);
          mode_nxt = M_IDLE;
          run_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (char_code == "\"") begin
          va       = 1'b1;
          tok_a    = mk_tok(K_STRING, SUB_NONE, start_r, len_r);
          mode_nxt = M_IDLE;
        end else if (char_code == 8'h00 || char_code == 8'h0A) begin
          va       = 1'b1;
          tok_a    = mk_tok(K_ERROR, ERR_STRING, pos_r, 16'd0);
          mode_nxt = M_HALTED;
        end else begin
          len_nxt = sat_inc(len_r);
        end
      end
      M_GOT_BANG: begin
        va = 1'b1;
        if (char_code == "=") begin
          tok_a    = mk_tok(K_OPERATOR, OP_NE, start_r, 16'd2);
          mode_nxt = M_IDLE;
        end else begin
          tok_a    = mk_tok(K_ERROR, ERR_BANG, start_r, 16'd1);
          mode_nxt = M_HALTED;
        end
      end
      M_GOT_EQ, M_GOT_GT, M_GOT_LT: begin
        va       = 1'b1;
        mode_nxt = M_IDLE;
        if (char_code == "=") begin
          tok_a = mk_tok(K_OPERATOR, (mode_r == M_GOT_EQ) ? OP_EQ :
                         (mode_r == M_GOT_GT) ? OP_GE : OP_LE, start_r, 16'd2);
        end else begin
          run_idle = 1'b1;
          if (mode_r == M_GOT_EQ) tok_a = mk_tok(K_ASSIGN, SUB_NONE, start_r, 16'd1);
          else tok_a = mk_tok(K_OPERATOR, (mode_r == M_GOT_GT) ? OP_GT : OP_LT,
                              start_r, 16'd1);
        end
      end
      M_ENDED, M_HALTED: ;
      default: ;
    endcase

    if (run_idle) begin
      if (is_alpha) begin
        mode_nxt   = M_IDENT;
        start_nxt  = pos_r;
        len_nxt    = 16'd1;
        prefix_nxt = PW'(char_code);
      end else if (is_digit) begin
        mode_nxt  = M_NUM_INT;
        start_nxt = pos_r;
        len_nxt   = 16'd1;
      end else begin
        case (char_code)
          8'h20, 8'h09, 8'h0D, 8'h0C: ;
          8'h00: begin
            vb = 1'b1; tok_b = mk_tok(K_EOF, SUB_NONE, pos_r, 16'd0); mode_nxt = M_ENDED;
          end
          8'h0A: begin vb = 1'b1; tok_b = mk_tok(K_NEWLINE, SUB_NONE, pos_r, 16'd1); end
          "\"": begin
            mode_nxt  = M_STRING;
            start_nxt = pos_r + 16'd1;
            len_nxt   = 16'd0;
          end
          "(": begin vb = 1'b1; tok_b = mk_tok(K_LPAREN, SUB_NONE, pos_r, 16'd1); end
          ")": begin vb = 1'b1; tok_b = mk_tok(K_RPAREN, SUB_NONE, pos_r, 16'd1); end
          "{": begin vb = 1'b1; tok_b = mk_tok(K_LBRACE, SUB_NONE, pos_r, 16'd1); end
          "}": begin vb = 1'b1; tok_b = mk_tok(K_RBRACE, SUB_NONE, pos_r, 16'd1); end
          "[": begin vb = 1'b1; tok_b = mk_tok(K_LBRACKET, SUB_NONE, pos_r, 16'd1); end
          "]": begin vb = 1'b1; tok_b = mk_tok(K_RBRACKET, SUB_NONE, pos_r, 16'd1); end
          ",": begin vb = 1'b1; tok_b = mk_tok(K_COMMA, SUB_NONE, pos_r, 16'd1); end
          ";": begin vb = 1'b1; tok_b = mk_tok(K_SEMI, SUB_NONE, pos_r, 16'd1); end
          "=": begin mode_nxt = M_GOT_EQ;   start_nxt = pos_r; len_nxt = 16'd1; end
          "!": begin mode_nxt = M_GOT_BANG; start_nxt = pos_r; len_nxt = 16'd1; end
          ">": begin mode_nxt = M_GOT_GT;   start_nxt = pos_r; len_nxt = 16'd1; end
          "<": begin mode_nxt = M_GOT_LT;   start_nxt = pos_r; len_nxt = 16'd1; end
          "+": begin vb = 1'b1; tok_b = mk_tok(K_OPERATOR, OP_ADD, pos_r, 16'd1); end
          "-": begin vb = 1'b1; tok_b = mk_tok(K_OPERATOR, OP_SUB, pos_r, 16'd1); end
          "*": begin vb = 1'b1; tok_b = mk_tok(K_OPERATOR, OP_MUL, pos_r, 16'd1); end
          "/": begin vb = 1'b1; tok_b = mk_tok(K_OPERATOR, OP_DIV, pos_r, 16'd1); end
          "&": begin
            vb = 1'b1; tok_b = mk_tok(K_ERROR, ERR_AMP, pos_r, 16'd1); mode_nxt = M_HALTED;
          end
          "|": begin
            vb = 1'b1; tok_b = mk_tok(K_ERROR, ERR_PIPE, pos_r, 16'd1); mode_nxt = M_HALTED;
          end
          default: begin
            vb = 1'b1; tok_b = mk_tok(K_ERROR, ERR_BYTE, pos_r, 16'd1); mode_nxt = M_HALTED;
          end
        endcase
      end
    end
    tok_a.last = !vb;
    tok_b.last = 1'b1;
  end

  // Compact the one or two tokens into the queue request.
  always_comb begin
    push.cnt    = in_fire ? ({1'b0, va} + {1'b0, vb}) : 2'd0;
    push.first  = va ? tok_a : tok_b;
    push.second = tok_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      start_r  <= '0;
      len_r    <= '0;
      prefix_r <= '0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_r + 16'd1;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

### sv/sct_queue.sv
`timescale 1ns / 1ps
module sct_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sct_pkg::push_t           push,
  input  logic                     pop,
  output sct_pkg::tok_t            head,
  output logic [sct_pkg::Q_CW-1:0] count
);
  import sct_pkg::*;

  tok_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_CW-1:0] count_r;

  assign head  = slot_r[rd_r];
  assign count = count_r;

  // Up to two writes a cycle at consecutive slots.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) slot_r[wr_r] <= push.first;
    if (push.cnt == 2'd2) slot_r[wr_r + Q_AW'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_r + Q_AW'(push.cnt);
      rd_r    <= rd_r + Q_AW'(pop);
      count_r <= count_r + Q_CW'(push.cnt) - Q_CW'(pop);
    end
  end

endmodule

### sv/sct_back.sv
`timescale 1ns / 1ps
module sct_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sct_pkg::tok_t            head,
  input  logic [sct_pkg::Q_CW-1:0] count,
  output logic                     pop,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [47:0]              out_tdata,
  output logic                     out_tlast
);
  import sct_pkg::*;

  logic       valid_r;
  logic [4:0] kind_r;
  logic [3:0] sub_r;
  logic [15:0] start_r, len_r;
  logic       last_r;
  cls_t       cls;

  // Identifiers are resolved to keywords and type names here.
  always_comb begin
    if (head.kind == K_IDENT) cls = word_lookup(head.prefix, head.len);
    else begin
      cls.kind = head.kind;
      cls.sub  = head.sub;
    end
  end

  assign pop = (count != '0) && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (!valid_r || out_tready) valid_r <= (count != '0);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= cls.kind;
      sub_r   <= cls.sub;
      start_r <= head.start;
      len_r   <= head.len;
      last_r  <= head.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0, len_r, start_r, sub_r, kind_r};
  assign out_tlast  = last_r;

endmodule

### sv/script_char_tokenizer_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Payload
// in_     | slave     | tdata[7:0] char_code
// out_    | master    | tdata: token_kind, sub_code, start_pos, lexeme_len; tlast last_of_run
//
// A byte is taken in the cycle it is offered while at most two tokens wait in the
// queue; its tokens pass via the queue to the output register, one per cycle when
// not stalled. A byte closing one token and opening another yields two tokens, one
// more than the output drains, so the input pauses only while more than two wait.
// rst_n is synchronous; it clears the scanner mode, counters, queue pointers and out valid.
// Either side may stall freely; the queue decouples the scanner from the output.
module script_char_tokenizer_core #(
  parameter int PREFIX_BYTES = sct_pkg::PREFIX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // token_kind, sub_code, start_pos, lexeme_len, zero fill
  output logic        out_tlast   // last_of_run
);
  import sct_pkg::*;

  push_t           push;
  tok_t            head;
  logic [Q_CW-1:0] count;
  logic            pop, in_fire;

  // Room for the worst case of two tokens from one byte.
  assign in_tready = count <= Q_CW'(Q_DEPTH - 2);
  assign in_fire   = in_tvalid && in_tready;

  sct_front #(.PREFIX_BYTES(PREFIX_BYTES)) u_front (
    .clk, .rst_n, .in_fire, .char_code(in_tdata), .push
  );

  sct_queue u_queue (.clk, .rst_n, .push, .pop, .head, .count);

  sct_back u_back (
    .clk, .rst_n, .head, .count, .pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= Q_CW'(Q_DEPTH)) else $error("token queue overflow");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] <= K_ERROR) else $error("token kind out of range");

  a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[4:0] == K_EOF) |-> (out_tdata[40:25] == 16'd0 && out_tlast))
    else $error("end token malformed");
`endif

endmodule
